### rtl/core/carc_pkg.sv
`default_nettype none
package carc_pkg;

  // Event codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SEND  = 3'd1;
  localparam logic [2:0] CMD_REPLY = 3'd2;
  localparam logic [2:0] CMD_HBEAT = 3'd3;
  localparam logic [2:0] CMD_OTHER = 3'd4;

  // Action codes
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_RESEND  = 3'd2;
  localparam logic [2:0] ACT_PING    = 3'd3;
  localparam logic [2:0] ACT_ABANDON = 3'd4;

  // Relay state codes
  localparam logic [1:0] RS_UNKNOWN = 2'd0;
  localparam logic [1:0] RS_OFF     = 2'd1;
  localparam logic [1:0] RS_ON      = 2'd2;

  // Relay numbers as carried on the ports
  localparam logic [1:0] RELAY_ONE = 2'd1;
  localparam logic [1:0] RELAY_TWO = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [1:0] REG_PING_INTERVAL = 2'd2;

  localparam logic [19:0] ACK_TIMEOUT_RST   = 20'd5000;
  localparam logic [2:0]  RETRY_LIMIT_RST   = 3'd5;
  localparam logic [31:0] PING_INTERVAL_RST = 32'd150000;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [19:0] ack_timeout_ms;
    logic [2:0]  retry_limit;
    logic [31:0] ping_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [1:0]  relay_select;
    logic        relay_on;
    logic        hb_relay_a_on;
    logic        hb_relay_b_present;
    logic        hb_relay_b_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] out_relay;
    logic       out_on;
    logic [2:0] retry_count;
    logic [1:0] relay_a_state;
    logic [1:0] relay_b_state;
    logic       pending;
    logic       last;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/carc_in_if.sv
`default_nettype none
interface carc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] now_ms;
  logic [1:0]  relay_select;
  logic        relay_on;
  logic        hb_relay_a_on;
  logic        hb_relay_b_present;
  logic        hb_relay_b_on;

  modport source (
    output valid, command, now_ms, relay_select, relay_on,
           hb_relay_a_on, hb_relay_b_present, hb_relay_b_on,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, relay_select, relay_on,
           hb_relay_a_on, hb_relay_b_present, hb_relay_b_on,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/carc_out_if.sv
`default_nettype none
interface carc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [1:0] out_relay;
  logic       out_on;
  logic [2:0] retry_count;
  logic [1:0] relay_a_state;
  logic [1:0] relay_b_state;
  logic       pending;
  logic       last;

  modport source (
    output valid, action, out_relay, out_on, retry_count,
           relay_a_state, relay_b_state, pending, last,
    input  ready
  );
  modport sink (
    input  valid, action, out_relay, out_on, retry_count,
           relay_a_state, relay_b_state, pending, last,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/carc_core.sv
`default_nettype none
module carc_core
  import carc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      res0,
  output out_item_t      res1,
  output logic           two
);

  logic        pending_valid, pending_valid_next;
  logic        pending_relay, pending_relay_next;
  logic        pending_on, pending_on_next;
  logic [31:0] pending_sent_time, pending_sent_time_next;
  logic [2:0]  retries_done, retries_done_next;
  logic [31:0] last_ping_time, last_ping_time_next;
  logic [31:0] last_receive_time, last_receive_time_next;
  logic [1:0]  relay_one_state, relay_one_state_next;
  logic [1:0]  relay_two_state, relay_two_state_next;

  logic        sel_ok;
  logic [31:0] rx_age, ping_age, sent_age;
  logic        silent, ping_fire, retry_due, resend;
  logic [2:0]  act;
  logic        with_cmd;
  logic [1:0]  reported;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid     <= 1'b0;
      pending_relay     <= 1'b0;
      pending_on        <= 1'b0;
      pending_sent_time <= '0;
      retries_done      <= '0;
      last_ping_time    <= '0;
      last_receive_time <= '0;
      relay_one_state   <= RS_UNKNOWN;
      relay_two_state   <= RS_UNKNOWN;
    end else if (step) begin
      pending_valid     <= pending_valid_next;
      pending_relay     <= pending_relay_next;
      pending_on        <= pending_on_next;
      pending_sent_time <= pending_sent_time_next;
      retries_done      <= retries_done_next;
      last_ping_time    <= last_ping_time_next;
      last_receive_time <= last_receive_time_next;
      relay_one_state   <= relay_one_state_next;
      relay_two_state   <= relay_two_state_next;
    end
  end

  always_comb begin
    pending_valid_next     = pending_valid;
    pending_relay_next     = pending_relay;
    pending_on_next        = pending_on;
    pending_sent_time_next = pending_sent_time;
    retries_done_next      = retries_done;
    last_ping_time_next    = last_ping_time;
    last_receive_time_next = last_receive_time;
    relay_one_state_next   = relay_one_state;
    relay_two_state_next   = relay_two_state;

    sel_ok   = (item.relay_select == RELAY_ONE) || (item.relay_select == RELAY_TWO);
    reported = item.relay_on ? RS_ON : RS_OFF;

    rx_age   = item.now_ms - last_receive_time;
    ping_age = item.now_ms - last_ping_time;
    sent_age = item.now_ms - pending_sent_time;
    // A receive time of zero reads as never received: age is all ones
    silent    = (last_receive_time == '0) ? (cfg.ping_interval_ms != '1)
                                          : (rx_age > cfg.ping_interval_ms);
    ping_fire = 1'b0;
    retry_due = 1'b0;
    resend    = 1'b0;
    act       = ACT_NONE;
    with_cmd  = 1'b0;

    unique case (item.command)
      CMD_TICK: begin
        ping_fire = silent && (ping_age > cfg.ping_interval_ms);
        retry_due = pending_valid && (sent_age >= {12'd0, cfg.ack_timeout_ms});
        resend    = retry_due && (retries_done < cfg.retry_limit);
        if (ping_fire) last_ping_time_next = item.now_ms;
        if (retry_due) begin
          with_cmd = 1'b1;
          if (resend) begin
            retries_done_next      = retries_done + 3'd1;
            pending_sent_time_next = item.now_ms;
            act                    = ACT_RESEND;
          end else begin
            pending_valid_next = 1'b0;
            act                = ACT_ABANDON;
          end
        end else if (ping_fire) begin
          act = ACT_PING;
        end
      end
      CMD_SEND: begin
        if (sel_ok) begin
          pending_valid_next     = 1'b1;
          pending_relay_next     = (item.relay_select == RELAY_TWO);
          pending_on_next        = item.relay_on;
          pending_sent_time_next = item.now_ms;
          retries_done_next      = '0;
          act                    = ACT_SEND;
          with_cmd               = 1'b1;
        end
      end
      CMD_REPLY: begin
        last_receive_time_next = item.now_ms;
        if (sel_ok) begin
          if (item.relay_select == RELAY_ONE) relay_one_state_next = reported;
          else                                relay_two_state_next = reported;
          if (pending_valid && (pending_relay == (item.relay_select == RELAY_TWO))
              && (pending_on == item.relay_on))
            pending_valid_next = 1'b0;
        end
      end
      CMD_HBEAT: begin
        last_receive_time_next = item.now_ms;
        relay_one_state_next   = item.hb_relay_a_on ? RS_ON : RS_OFF;
        if (item.hb_relay_b_present)
          relay_two_state_next = item.hb_relay_b_on ? RS_ON : RS_OFF;
      end
      CMD_OTHER: begin
        last_receive_time_next = item.now_ms;
      end
      default: begin
      end
    endcase

    // Result after the whole update; a lone ping uses this too
    res1.action        = act;
    res1.out_relay     = with_cmd ? (pending_relay_next ? RELAY_TWO : RELAY_ONE) : 2'd0;
    res1.out_on        = with_cmd && pending_on_next;
    res1.retry_count   = retries_done_next;
    res1.relay_a_state = relay_one_state_next;
    res1.relay_b_state = relay_two_state_next;
    res1.pending       = pending_valid_next;
    res1.last          = 1'b1;

    two = ping_fire && retry_due;
    // Ping ahead of a retry result: state as before the retry
    res0 = res1;
    if (two) begin
      res0.action      = ACT_PING;
      res0.out_relay   = 2'd0;
      res0.out_on      = 1'b0;
      res0.retry_count = retries_done;
      res0.pending     = pending_valid;
      res0.last        = 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/carc_result_fifo.sv
`default_nettype none
module carc_result_fifo
  import carc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       push_two,
  input  wire out_item_t  d0,
  input  wire out_item_t  d1,
  output logic            room_two,
  carc_out_if.source      results
);

  out_item_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wptr, rptr;
  logic [RES_CNT_W-1:0]   count, count_next;
  logic                   pop;
  out_item_t              head;

  assign pop      = results.valid && results.ready;
  assign room_two = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign head     = mem[rptr];

  always_comb begin
    count_next = count;
    if (push)     count_next = count_next + RES_CNT_W'(1);
    if (push_two) count_next = count_next + RES_CNT_W'(1);
    if (pop)      count_next = count_next - RES_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) rptr <= rptr + RES_PTR_W'(1);
      if (push) wptr <= wptr + (push_two ? RES_PTR_W'(2) : RES_PTR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= d0;
      if (push_two) mem[wptr + RES_PTR_W'(1)] <= d1;
    end
  end

  assign results.valid         = (count != '0);
  assign results.action        = head.action;
  assign results.out_relay     = head.out_relay;
  assign results.out_on        = head.out_on;
  assign results.retry_count   = head.retry_count;
  assign results.relay_a_state = head.relay_a_state;
  assign results.relay_b_state = head.relay_b_state;
  assign results.pending       = head.pending;
  assign results.last          = head.last;

endmodule
`default_nettype wire

### rtl/core/command_ack_retry_controller_unit.sv
// Channel   Dir  Handshake      Payload
// events    in   valid/ready    command, now_ms, relay_select, relay_on, hb_* fields
// results   out  valid/ready    action, out_relay, out_on, retry_count, relay states,
//                               pending, last
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// One item per cycle while the queue has room for two results: an item lands in
// the input register, then the state update runs and writes one or two results
// into a four-entry queue; a result shows on results once it is in the queue.
// A tick that fires both a ping and a retry gives two results; the queue drains
// at most one per cycle, so a run of such ticks holds events.ready low as it fills.
// Reset (rst, synchronous) clears state, the queue and loads register defaults.
`default_nettype none
module command_ack_retry_controller_unit
  import carc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  carc_in_if.sink          events,
  carc_out_if.source       results
);

  cfg_t       cfg;
  in_item_t   in_q;
  logic       in_v;
  logic       room_two, step, two;
  out_item_t  res0, res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_timeout_ms   <= ACK_TIMEOUT_RST;
      cfg.retry_limit      <= RETRY_LIMIT_RST;
      cfg.ping_interval_ms <= PING_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_TIMEOUT:   cfg.ack_timeout_ms   <= cfg_data[19:0];
        REG_RETRY_LIMIT:   cfg.retry_limit      <= cfg_data[2:0];
        REG_PING_INTERVAL: cfg.ping_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Process the held item only when the queue can take two results
  assign step         = in_v && room_two;
  assign events.ready = !in_v || room_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (events.ready) begin
      in_v <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      in_q.command            <= events.command;
      in_q.now_ms             <= events.now_ms;
      in_q.relay_select       <= events.relay_select;
      in_q.relay_on           <= events.relay_on;
      in_q.hb_relay_a_on      <= events.hb_relay_a_on;
      in_q.hb_relay_b_present <= events.hb_relay_b_present;
      in_q.hb_relay_b_on      <= events.hb_relay_b_on;
    end
  end

  carc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .cfg  (cfg),
    .res0 (res0),
    .res1 (res1),
    .two  (two)
  );

  carc_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (step),
    .push_two (step && two),
    .d0       (res0),
    .d1       (res1),
    .room_two (room_two),
    .results  (results)
  );

endmodule
`default_nettype wire

### tb/sv/tb_command_ack_retry_controller_unit.sv
`timescale 1ns / 1ps
module tb_command_ack_retry_controller_unit;
  import carc_pkg::*;

  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  localparam logic [31:0] NEVER_HEARD     = 32'hFFFF_FFFF;

  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  carc_in_if  ev_if ();
  carc_out_if res_if ();

  command_ack_retry_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev_if),
    .results   (res_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Controller copy: configuration and link state
  logic [19:0] ack_wait;
  logic [2:0]  retry_limit;
  logic [31:0] ping_every;
  logic        cmd_waiting;
  logic        cmd_relay_two;
  logic        cmd_on;
  logic [31:0] cmd_stamp;
  logic [2:0]  resends;
  logic [31:0] ping_stamp;
  logic [31:0] heard_stamp;
  logic [1:0]  relay1_st;
  logic [1:0]  relay2_st;

  out_item_t expected_q[$];
  in_item_t  event_q[$];

  int events_queued;
  int events_taken;
  int results_seen;
  int errors;
  bit steady;

  // Stimulus generator state
  logic [31:0] clock_ms;
  logic [1:0]  sent_relay;
  logic        sent_on;

  function automatic void reset_controller();
    ack_wait      = ACK_TIMEOUT_RST;
    retry_limit   = RETRY_LIMIT_RST;
    ping_every    = PING_INTERVAL_RST;
    cmd_waiting   = 1'b0;
    cmd_relay_two = 1'b0;
    cmd_on        = 1'b0;
    cmd_stamp     = '0;
    resends       = '0;
    ping_stamp    = '0;
    heard_stamp   = '0;
    relay1_st     = RS_UNKNOWN;
    relay2_st     = RS_UNKNOWN;
  endfunction

  function automatic out_item_t link_snapshot(logic [2:0] act, bit with_cmd);
    out_item_t r;
    r.action        = act;
    r.out_relay     = with_cmd ? (cmd_relay_two ? RELAY_TWO : RELAY_ONE) : 2'd0;
    r.out_on        = with_cmd ? cmd_on : 1'b0;
    r.retry_count   = resends;
    r.relay_a_state = relay1_st;
    r.relay_b_state = relay2_st;
    r.pending       = cmd_waiting;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic void predict_actions(in_item_t e);
    out_item_t res [2];
    int n;
    logic [31:0] silence;
    logic [31:0] since_ping;
    logic [31:0] since_cmd;
    bit sel_ok;
    logic [1:0] st;
    n = 0;
    sel_ok = (e.relay_select == RELAY_ONE) || (e.relay_select == RELAY_TWO);
    st = e.relay_on ? RS_ON : RS_OFF;
    case (e.command)
      CMD_TICK: begin
        silence    = (heard_stamp == '0) ? NEVER_HEARD : e.now_ms - heard_stamp;
        since_ping = e.now_ms - ping_stamp;
        if (silence > ping_every && since_ping > ping_every) begin
          ping_stamp = e.now_ms;
          res[n] = link_snapshot(ACT_PING, 1'b0);
          n++;
        end
        since_cmd = e.now_ms - cmd_stamp;
        if (cmd_waiting && since_cmd >= {12'd0, ack_wait}) begin
          if (resends < retry_limit) begin
            resends   = resends + 3'd1;
            cmd_stamp = e.now_ms;
            res[n] = link_snapshot(ACT_RESEND, 1'b1);
          end else begin
            cmd_waiting = 1'b0;
            res[n] = link_snapshot(ACT_ABANDON, 1'b1);
          end
          n++;
        end
      end
      CMD_SEND: begin
        if (sel_ok) begin
          cmd_waiting   = 1'b1;
          cmd_relay_two = (e.relay_select == RELAY_TWO);
          cmd_on        = e.relay_on;
          cmd_stamp     = e.now_ms;
          resends       = '0;
          res[n] = link_snapshot(ACT_SEND, 1'b1);
          n++;
        end
      end
      CMD_REPLY: begin
        heard_stamp = e.now_ms;
        if (sel_ok) begin
          if (e.relay_select == RELAY_ONE) relay1_st = st;
          else relay2_st = st;
          // clear only on a reply naming both relay and state
          if (cmd_waiting && cmd_relay_two == (e.relay_select == RELAY_TWO) &&
              cmd_on == e.relay_on)
            cmd_waiting = 1'b0;
        end
      end
      CMD_HBEAT: begin
        heard_stamp = e.now_ms;
        relay1_st = e.hb_relay_a_on ? RS_ON : RS_OFF;
        if (e.hb_relay_b_present) relay2_st = e.hb_relay_b_on ? RS_ON : RS_OFF;
      end
      CMD_OTHER: heard_stamp = e.now_ms;
      default: ;
    endcase
    if (n == 0) begin
      res[n] = link_snapshot(ACT_NONE, 1'b0);
      n++;
    end
    res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
  endfunction

  function automatic in_item_t make_event(logic [2:0] c, logic [31:0] t, logic [1:0] sel,
                                          logic on, logic a, logic bp, logic b);
    in_item_t e;
    e.command            = c;
    e.now_ms             = t;
    e.relay_select       = sel;
    e.relay_on           = on;
    e.hb_relay_a_on      = a;
    e.hb_relay_b_present = bp;
    e.hb_relay_b_on      = b;
    return e;
  endfunction

  // Mostly advancing time with command/reply pairs; some noise and odd stamps
  function automatic in_item_t random_event(int unsigned step);
    in_item_t e;
    int unsigned pick;
    int unsigned stamp_pick;
    e = make_event(CMD_TICK, '0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    stamp_pick = $urandom_range(0, 99);
    if (stamp_pick < 4) begin
      e.now_ms = $urandom();
    end else if (stamp_pick < 7) begin
      e.now_ms = '0;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step);
      e.now_ms = clock_ms;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      e.command = CMD_TICK;
    end else if (pick < 55) begin
      e.command = CMD_SEND;
      if ($urandom_range(0, 9) != 0) begin
        e.relay_select = $urandom_range(0, 1) ? RELAY_TWO : RELAY_ONE;
        sent_relay = e.relay_select;
        sent_on    = e.relay_on;
      end
    end else if (pick < 75) begin
      e.command = CMD_REPLY;
      if ($urandom_range(0, 9) < 6) begin
        e.relay_select = sent_relay;
        e.relay_on     = sent_on;
      end
    end else if (pick < 85) begin
      e.command = CMD_HBEAT;
    end else if (pick < 96) begin
      e.command = CMD_OTHER;
    end else begin
      e.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
    return e;
  endfunction

  task automatic queue_event(in_item_t e);
    event_q.push_back(e);
    events_queued++;
  endtask

  task automatic wait_idle();
    while (events_taken != events_queued || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACK_TIMEOUT:   ack_wait    = value[19:0];
      REG_RETRY_LIMIT:   retry_limit = value[2:0];
      REG_PING_INTERVAL: ping_every  = value;
      default: ;
    endcase
  endtask

  task automatic run_random(int count, int unsigned step);
    for (int i = 0; i < count; i++) queue_event(random_event(step));
    wait_idle();
  endtask

  task automatic set_link(logic [31:0] ack, logic [31:0] retries, logic [31:0] ping);
    write_reg(REG_ACK_TIMEOUT, ack);
    write_reg(REG_RETRY_LIMIT, retries);
    write_reg(REG_PING_INTERVAL, ping);
  endtask

  // Event driver
  in_item_t on_bus;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      ev_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        predict_actions(on_bus);
        events_taken++;
      end
      if (ev_if.valid && !ev_if.ready) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        gap_left--;
        ev_if.valid <= 1'b0;
      end else if (!steady && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(1, 11) - 1;
        ev_if.valid <= 1'b0;
      end else if (event_q.size() > 0) begin
        on_bus = event_q.pop_front();
        ev_if.command            <= on_bus.command;
        ev_if.now_ms             <= on_bus.now_ms;
        ev_if.relay_select       <= on_bus.relay_select;
        ev_if.relay_on           <= on_bus.relay_on;
        ev_if.hb_relay_a_on      <= on_bus.hb_relay_a_on;
        ev_if.hb_relay_b_present <= on_bus.hb_relay_b_present;
        ev_if.hb_relay_b_on      <= on_bus.hb_relay_b_on;
        ev_if.valid              <= 1'b1;
      end else begin
        ev_if.valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: result %0d %s expected %0d got %0d", $time, results_seen, name,
               want, got);
      errors++;
    end
  endfunction

  // Result monitor
  int stall_left;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.action        = res_if.action;
        got.out_relay     = res_if.out_relay;
        got.out_on        = res_if.out_on;
        got.retry_count   = res_if.retry_count;
        got.relay_a_state = res_if.relay_a_state;
        got.relay_b_state = res_if.relay_b_state;
        got.pending       = res_if.pending;
        got.last          = res_if.last;
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: result %0d with none expected, action %0d", $time,
                   results_seen, got.action);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("action", want.action, got.action);
          check_field("out_relay", want.out_relay, got.out_relay);
          check_field("out_on", want.out_on, got.out_on);
          check_field("retry_count", want.retry_count, got.retry_count);
          check_field("relay_a_state", want.relay_a_state, got.relay_a_state);
          check_field("relay_b_state", want.relay_b_state, got.relay_b_state);
          check_field("pending", want.pending, got.pending);
          check_field("last", want.last, got.last);
        end
      end
      // one long hold so the result queue fills and events back up
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!steady && !hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  int stuck_cycles;

  always @(posedge clk) begin
    if (rst || (ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    ev_if.valid              = 1'b0;
    ev_if.command            = '0;
    ev_if.now_ms             = '0;
    ev_if.relay_select       = '0;
    ev_if.relay_on           = 1'b0;
    ev_if.hb_relay_a_on      = 1'b0;
    ev_if.hb_relay_b_present = 1'b0;
    ev_if.hb_relay_b_on      = 1'b0;
    res_if.ready             = 1'b0;
    events_queued = 0;
    events_taken  = 0;
    results_seen  = 0;
    errors        = 0;
    steady        = 1'b0;
    clock_ms      = '0;
    sent_relay    = RELAY_ONE;
    sent_on       = 1'b0;
    reset_controller();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on reset settings
    queue_event(make_event(CMD_TICK, 32'd0, RELAY_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_TICK, 32'd150001, RELAY_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_SEND, 32'd150010, RELAY_ONE, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_SEND, 32'd150011, 2'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_event(make_event(CMD_SEND, 32'd150012, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_TICK, 32'd155010, RELAY_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd155020, RELAY_TWO, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd155030, RELAY_ONE, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd155040, RELAY_ONE, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd0, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_event(make_event(CMD_HBEAT, 32'd160000, RELAY_ONE, 1'b0, 1'b1, 1'b0, 1'b1));
    queue_event(make_event(CMD_HBEAT, 32'd160010, RELAY_ONE, 1'b0, 1'b0, 1'b1, 1'b0));
    queue_event(make_event(CMD_HBEAT, 32'd160020, RELAY_ONE, 1'b0, 1'b1, 1'b1, 1'b1));
    queue_event(make_event(CMD_OTHER, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_event(make_event(CMD_UNUSED_FIRST, 32'd0, RELAY_ONE, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_event(make_event(CMD_UNUSED_LAST, 32'hFFFF_FFFF, RELAY_TWO, 1'b1, 1'b1, 1'b1,
                           1'b1));
    queue_event(make_event(CMD_SEND, 32'd200000, RELAY_TWO, 1'b0, 1'b0, 1'b0, 1'b0));
    // ping and resend on the same tick, then run out the retries
    for (int i = 0; i < 6; i++)
      queue_event(make_event(CMD_TICK, 32'd400000 + i * 5000, RELAY_ONE, 1'b0, 1'b0, 1'b0,
                             1'b0));
    wait_idle();

    set_link(32'd0, 32'd0, 32'd0);
    clock_ms = 32'd1000;
    run_random(60, 3);

    set_link(32'h000F_FFFF, 32'd7, 32'hFFFF_FFFF);
    clock_ms = 32'hFFF0_0000;
    run_random(60, 1200000);

    set_link(32'd40, 32'd3, 32'd150);
    run_random(90, 60);

    for (int p = 0; p < 2; p++) begin
      set_link($urandom_range(0, 200), $urandom_range(0, 7), $urandom_range(0, 500));
      run_random(80, 250);
    end

    steady = 1'b1;
    set_link(32'd10, 32'd2, 32'd30);
    run_random(70, 20);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
